// ===== sv/idrc_pkg.sv =====
// idrc_pkg: constants, result type and CRC-16/ARC byte update for the ID reply checker.
// No dependencies; used by idrc_parser and id_reply_checker.
package idrc_pkg;

    localparam int unsigned ID_BYTES = 16;
    localparam int unsigned ID_CNT_W = $clog2(ID_BYTES);

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  HOP_BYTE  = 8'h00;
    localparam logic [7:0]  MARK_BYTE = 8'h01;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic        ok;
        logic [7:0]  index_echo;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [31:0] failures;
    } t_result;

    // reflected CRC, one byte, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/idrc_parser.sv =====
// idrc_parser: reply parse state, CRC check and failure count.
// Depends on idrc_pkg. Result is combinational from the parse state and the item presented with i_take.
module idrc_parser #(
    parameter int unsigned MAX_HOPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_kind,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_index,
    output idrc_pkg::t_result  o_result
);

    localparam int unsigned HOP_W = $clog2(MAX_HOPS + 1);
    localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(MAX_HOPS);
    localparam logic [idrc_pkg::ID_CNT_W-1:0] LAST_ID =
        idrc_pkg::ID_CNT_W'(idrc_pkg::ID_BYTES - 1);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_ID,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_GOOD,
        PH_BAD
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [HOP_W-1:0]             r_hops, n_hops;
    logic [idrc_pkg::ID_CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]                  r_crc, n_crc;
    logic [7:0]                   r_crc_lo, n_crc_lo;
    logic [63:0]                  r_id_hi, n_id_hi;
    logic [63:0]                  r_id_lo, n_id_lo;
    logic [31:0]                  r_fail, n_fail;
    logic                         good;

    assign good = (r_phase == PH_GOOD);

    always_comb begin
        n_phase  = r_phase;
        n_hops   = r_hops;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_id_hi  = r_id_hi;
        n_id_lo  = r_id_lo;
        n_fail   = r_fail;
        if (i_take) begin
            if (i_kind == idrc_pkg::KIND_END) begin
                if (!good && r_fail != 32'hFFFF_FFFF) begin
                    n_fail = r_fail + 32'd1;
                end
                n_phase = PH_SKIP;
                n_hops  = '0;
                n_cnt   = '0;
                n_crc   = '0;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if (i_byte == idrc_pkg::HOP_BYTE) begin
                            if (r_hops < HOP_LIMIT) begin
                                n_hops = r_hops + HOP_W'(1);
                            end else begin
                                n_phase = PH_BAD;
                            end
                        end else if (i_byte == idrc_pkg::MARK_BYTE) begin
                            n_phase = PH_ID;
                            n_cnt   = '0;
                            n_crc   = '0;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                    PH_ID: begin
                        if (!r_cnt[idrc_pkg::ID_CNT_W-1]) begin
                            n_id_hi = {r_id_hi[55:0], i_byte};
                        end else begin
                            n_id_lo = {r_id_lo[55:0], i_byte};
                        end
                        n_crc = idrc_pkg::crc_byte(r_crc, i_byte);
                        n_cnt = r_cnt + idrc_pkg::ID_CNT_W'(1);
                        if (r_cnt == LAST_ID) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        n_crc_lo = i_byte;
                        n_phase  = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        n_phase = ({i_byte, r_crc_lo} == r_crc) ? PH_GOOD : PH_BAD;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_hops  <= '0;
            r_cnt   <= '0;
            r_crc   <= '0;
            r_fail  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hops  <= n_hops;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_fail  <= n_fail;
        end
        r_crc_lo <= n_crc_lo;
        r_id_hi  <= n_id_hi;
        r_id_lo  <= n_id_lo;
    end

    always_comb begin
        o_result.ok         = good;
        o_result.index_echo = i_index;
        o_result.id_high    = good ? r_id_hi : 64'd0;
        o_result.id_low     = good ? r_id_lo : 64'd0;
        o_result.failures   = n_fail;
    end

endmodule

// ===== sv/id_reply_checker.sv =====
// id_reply_checker: top level, input item register, parser and result register.
// Depends on idrc_pkg and idrc_parser.
//
// channel   dir  tdata                                              tuser
// s_axis    in   [7:0] reply_byte, [15:8] square_index              kind
// m_axis    out  [7:0] index_echo, [71:8] id_high, [135:72] id_low,  ok
//                [167:136] failures
//
// One item per cycle unless an end item meets a held result; a result is registered in r_out.
// The parser advances as the input register drains; only end items need the result register.
// Downstream stall holds the result; upstream keeps flowing while the register drains.
// Reset synchronous, active low; clears parse state and the failure count.
module id_reply_checker #(
    parameter int unsigned MAX_HOPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // reply_byte, square_index
    input  logic          s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [167:0]  m_axis_tdata,   // index_echo, id_high, id_low, failures
    output logic          m_axis_tuser    // ok
);

    logic              r_in_valid;
    logic              r_in_kind;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_in_index;
    logic              r_out_valid;
    idrc_pkg::t_result r_out;
    idrc_pkg::t_result res;
    logic              out_free;
    logic              advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (r_in_kind == idrc_pkg::KIND_DATA || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    idrc_parser #(
        .MAX_HOPS (MAX_HOPS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (advance),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_index  (r_in_index),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance && r_in_kind == idrc_pkg::KIND_END) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind  <= s_axis_tuser;
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_index <= s_axis_tdata[15:8];
        end
        if (advance && r_in_kind == idrc_pkg::KIND_END) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.ok;
    assign m_axis_tdata  = {r_out.failures, r_out.id_low, r_out.id_high, r_out.index_echo};

    // a failed result always carries a non-zero count
    a_fail_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |-> (r_out.failures != 32'd0))
        else $error("failed result with zero failure count");

    // a failed result shows no ID
    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |-> (r_out.id_high == 64'd0 && r_out.id_low == 64'd0))
        else $error("failed result carries ID");

    // results come only from end items
    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_kind == idrc_pkg::KIND_DATA) |=> !$rose(r_out_valid))
        else $error("data item produced a result");

    // a result under stall is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost");

endmodule
